@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both forms compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, held off while reset is asserted.
`define MQF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define MQF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MQF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MQF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/mqf_pkg.sv @@
package mqf_pkg;

    localparam int NUM_QUEUES     = 3;
    localparam int MAX_SLOTS      = 4;
    localparam int MAX_SLOT_BYTES = 32;

    localparam int QID_W      = 2;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int OFS_W      = $clog2(MAX_SLOT_BYTES);
    localparam int LEN_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int NSLOT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam int PAY_DEPTH = NUM_QUEUES * MAX_SLOTS * MAX_SLOT_BYTES;
    localparam int PAY_AW    = $clog2(PAY_DEPTH);
    localparam int LEN_DEPTH = NUM_QUEUES * MAX_SLOTS;
    localparam int LEN_AW    = $clog2(LEN_DEPTH);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_TOO_LONG = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_BASE = CFG_IDX_W'(NUM_QUEUES);
    localparam logic [CFG_IDX_W-1:0] CFG_END        = CFG_IDX_W'(2 * NUM_QUEUES);

    localparam logic [NSLOT_W-1:0] SLOTS_RESET = NSLOT_W'(1);
    localparam logic [LEN_W-1:0]   BYTES_RESET [NUM_QUEUES] = '{6'd32, 6'd17, 6'd1};

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_LEN,
        S_POP_DATA
    } state_t;

    typedef struct packed {
        logic              mode;
        logic [QID_W-1:0]  queue_id;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              last;
    } req_t;

    typedef struct packed {
        logic              kind;
        logic [1:0]        status;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              out_last;
    } resp_t;

    typedef struct packed {
        logic              en;
        logic [QID_W-1:0]  q;
        logic [SLOT_W-1:0] slot;
        logic [OFS_W-1:0]  ofs;
        logic [BYTE_W-1:0] data;
    } pay_wr_t;

    typedef struct packed {
        logic              en;
        logic [QID_W-1:0]  q;
        logic [SLOT_W-1:0] slot;
        logic [OFS_W-1:0]  ofs;
    } pay_rd_t;

    typedef struct packed {
        logic              en;
        logic [QID_W-1:0]  q;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
    } len_wr_t;

    typedef struct packed {
        logic              en;
        logic [QID_W-1:0]  q;
        logic [SLOT_W-1:0] slot;
    } len_rd_t;

    // Saturate a slot count to 1..MAX_SLOTS.
    function automatic logic [NSLOT_W-1:0] slots_clamp(input logic [NSLOT_W-1:0] v);
        logic [NSLOT_W-1:0] r;
        if (v == '0)
            r = NSLOT_W'(1);
        else if (v > NSLOT_W'(MAX_SLOTS))
            r = NSLOT_W'(MAX_SLOTS);
        else
            r = v;
        return r;
    endfunction

    // Saturate a slot size to 1..MAX_SLOT_BYTES.
    function automatic logic [LEN_W-1:0] bytes_clamp(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > LEN_W'(MAX_SLOT_BYTES))
            r = LEN_W'(MAX_SLOT_BYTES);
        else
            r = v;
        return r;
    endfunction

endpackage

@@ rtl/core/mqf_store.sv @@
// Payload and slot-length memories, one write and one registered read port each.
module mqf_store (
    input  logic                          clk,
    input  mqf_pkg::pay_wr_t              pay_wr,
    input  mqf_pkg::pay_rd_t              pay_rd,
    output logic [mqf_pkg::BYTE_W-1:0]    pay_rdata,
    input  mqf_pkg::len_wr_t              len_wr,
    input  mqf_pkg::len_rd_t              len_rd,
    output logic [mqf_pkg::LEN_W-1:0]     len_rdata
);

    logic [mqf_pkg::BYTE_W-1:0] pay_mem [mqf_pkg::PAY_DEPTH];
    logic [mqf_pkg::LEN_W-1:0]  len_mem [mqf_pkg::LEN_DEPTH];

    logic [mqf_pkg::BYTE_W-1:0] pay_rdata_reg;
    logic [mqf_pkg::LEN_W-1:0]  len_rdata_reg;

    logic [mqf_pkg::PAY_AW-1:0] pay_waddr;
    logic [mqf_pkg::PAY_AW-1:0] pay_raddr;
    logic [mqf_pkg::LEN_AW-1:0] len_waddr;
    logic [mqf_pkg::LEN_AW-1:0] len_raddr;

    function automatic logic [mqf_pkg::LEN_AW-1:0] slot_addr(
        input logic [mqf_pkg::QID_W-1:0]  q,
        input logic [mqf_pkg::SLOT_W-1:0] slot
    );
        return mqf_pkg::LEN_AW'(q) * mqf_pkg::LEN_AW'(mqf_pkg::MAX_SLOTS)
             + mqf_pkg::LEN_AW'(slot);
    endfunction

    function automatic logic [mqf_pkg::PAY_AW-1:0] byte_addr(
        input logic [mqf_pkg::QID_W-1:0]  q,
        input logic [mqf_pkg::SLOT_W-1:0] slot,
        input logic [mqf_pkg::OFS_W-1:0]  ofs
    );
        return mqf_pkg::PAY_AW'(slot_addr(q, slot)) * mqf_pkg::PAY_AW'(mqf_pkg::MAX_SLOT_BYTES)
             + mqf_pkg::PAY_AW'(ofs);
    endfunction

    assign pay_waddr = byte_addr(pay_wr.q, pay_wr.slot, pay_wr.ofs);
    assign pay_raddr = byte_addr(pay_rd.q, pay_rd.slot, pay_rd.ofs);
    assign len_waddr = slot_addr(len_wr.q, len_wr.slot);
    assign len_raddr = slot_addr(len_rd.q, len_rd.slot);

    always_ff @(posedge clk)
    begin
        if (pay_wr.en)
        begin
            pay_mem[pay_waddr] <= pay_wr.data;
        end
        if (pay_rd.en)
        begin
            pay_rdata_reg <= pay_mem[pay_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (len_wr.en)
        begin
            len_mem[len_waddr] <= len_wr.len;
        end
        if (len_rd.en)
        begin
            len_rdata_reg <= len_mem[len_raddr];
        end
    end

    // Read data holds until the next read enable.
    assign pay_rdata = pay_rdata_reg;
    assign len_rdata = len_rdata_reg;

endmodule

@@ rtl/core/multi_queue_message_fifo_unit.sv @@
// Three circular message queues over a shared payload memory (3 queues x 4 slots x 32 bytes)
// and a slot-length memory (12 entries), both with a registered read. Each request beat
// either pushes one byte of a message (mode 0) or pops a whole message (mode 1). Push beats
// are taken one per cycle while the response register is free; the beat marked last commits
// the message into the tail slot and returns one completion beat with status ok, full or
// too_long. A pop takes the request, reads the slot length, issues the first payload read,
// then streams one byte per cycle unless the response stalls; an empty message gets one
// closing beat instead. A pop of an empty queue is answered from the idle state with status
// empty. No request is taken while a pop streams out, so memory reads never overlap a write
// to the same entry. Slot count and slot size values saturate to 1..4 and 1..32 where used.
// The slot count and slot size registers must be written only while no message is being
// delivered; the block itself does not enforce this. Memory contents are undefined after
// reset; no clearing pass is needed since a slot is read only after it is committed.
`include "assert_macros.svh"

module multi_queue_message_fifo_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  mqf_pkg::req_t                     req,
    // response channel
    output logic                              resp_valid,
    input  logic                              resp_stall,
    output mqf_pkg::resp_t                    resp,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [mqf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mqf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NQ = mqf_pkg::NUM_QUEUES;

    // Configuration registers.
    logic [mqf_pkg::NSLOT_W-1:0] slots_reg [NQ];
    logic [mqf_pkg::LEN_W-1:0]   bytes_reg [NQ];

    // Per-queue ring state.
    logic [mqf_pkg::SLOT_W-1:0]  head_reg [NQ];
    logic [mqf_pkg::SLOT_W-1:0]  tail_reg [NQ];
    logic [NQ-1:0]               full_reg;
    logic [NQ-1:0]               empty_reg;

    // Message being pushed.
    logic [mqf_pkg::LEN_W-1:0]   pc_reg;
    logic [1:0]                  err_reg;

    // Pop sequencer.
    mqf_pkg::state_t             state_reg, state_next;
    logic [mqf_pkg::QID_W-1:0]   pop_q_reg;
    logic [mqf_pkg::SLOT_W-1:0]  pop_slot_reg;
    logic [mqf_pkg::LEN_W-1:0]   pop_len_reg;
    logic [mqf_pkg::LEN_W-1:0]   k_reg;
    logic                        rd_pend_reg;
    logic                        rd_last_reg;

    // Output register.
    logic                        out_v_reg;
    mqf_pkg::resp_t              out_reg;

    // Decode of the request beat.
    logic                        q_ok;
    logic [mqf_pkg::QID_W-1:0]   qi;
    logic [mqf_pkg::NSLOT_W-1:0] ns;
    logic [mqf_pkg::LEN_W-1:0]   sb;
    logic [mqf_pkg::SLOT_W-1:0]  t_cur, h_cur, t_adv, h_adv;
    logic                        q_full, q_empty;
    logic                        is_push, byte_in, room;
    logic [mqf_pkg::LEN_W-1:0]   pc1;
    logic [1:0]                  err1;
    logic [1:0]                  push_status;

    // Sequencer controls.
    logic                        out_free;
    logic                        accept;
    logic                        out_load;
    mqf_pkg::resp_t              out_data;
    logic                        commit;
    logic                        pop_start;
    logic                        issue;
    logic                        deliver;
    logic                        pop_done;

    mqf_pkg::pay_wr_t            pay_wr;
    mqf_pkg::pay_rd_t            pay_rd;
    mqf_pkg::len_wr_t            len_wr;
    mqf_pkg::len_rd_t            len_rd;
    logic [mqf_pkg::BYTE_W-1:0]  pay_rdata;
    logic [mqf_pkg::LEN_W-1:0]   len_rdata;

    mqf_store u_store (
        .clk       (clk),
        .pay_wr    (pay_wr),
        .pay_rd    (pay_rd),
        .pay_rdata (pay_rdata),
        .len_wr    (len_wr),
        .len_rd    (len_rd),
        .len_rdata (len_rdata)
    );

    // ------------------------------------------------------------------
    // Request decode: queue lookups, byte accounting and commit status.
    // ------------------------------------------------------------------
    always_comb
    begin
        q_ok    = req.queue_id < mqf_pkg::QID_W'(NQ);
        qi      = q_ok ? req.queue_id : '0;
        ns      = mqf_pkg::slots_clamp(slots_reg[qi]);
        sb      = mqf_pkg::bytes_clamp(bytes_reg[qi]);
        t_cur   = tail_reg[qi];
        h_cur   = head_reg[qi];
        q_full  = full_reg[qi];
        q_empty = empty_reg[qi];

        // Advance an index and wrap once it reaches the slot count in use.
        t_adv = (mqf_pkg::NSLOT_W'(t_cur) + mqf_pkg::NSLOT_W'(1) >= ns)
              ? '0 : t_cur + mqf_pkg::SLOT_W'(1);
        h_adv = (mqf_pkg::NSLOT_W'(h_cur) + mqf_pkg::NSLOT_W'(1) >= ns)
              ? '0 : h_cur + mqf_pkg::SLOT_W'(1);

        is_push = req.mode == mqf_pkg::MODE_PUSH;
        byte_in = is_push && req.byte_valid;
        room    = pc_reg < sb;

        // A full queue poisons the message; overflow marks it too long unless
        // it is already flagged.
        err1 = err_reg;
        pc1  = pc_reg;
        if (byte_in)
        begin
            if (q_full)
                err1 = mqf_pkg::STAT_FULL;
            if (room)
                pc1 = pc_reg + mqf_pkg::LEN_W'(1);
            else if (err1 == mqf_pkg::STAT_OK)
                err1 = mqf_pkg::STAT_TOO_LONG;
        end

        priority if (q_full || err1 == mqf_pkg::STAT_FULL)
            push_status = mqf_pkg::STAT_FULL;
        else if (err1 == mqf_pkg::STAT_TOO_LONG || pc1 > sb)
            push_status = mqf_pkg::STAT_TOO_LONG;
        else
            push_status = mqf_pkg::STAT_OK;
    end

    // ------------------------------------------------------------------
    // Sequencer outputs.
    // ------------------------------------------------------------------
    assign out_free = !out_v_reg || !resp_stall;

    always_comb
    begin
        req_stall = 1'b1;
        accept    = 1'b0;
        out_load  = 1'b0;
        out_data  = '0;
        commit    = 1'b0;
        pop_start = 1'b0;
        issue     = 1'b0;
        deliver   = 1'b0;
        pop_done  = 1'b0;

        pay_wr      = '0;
        pay_wr.q    = qi;
        pay_wr.slot = t_cur;
        pay_wr.ofs  = pc_reg[mqf_pkg::OFS_W-1:0];
        pay_wr.data = req.data_byte;

        len_wr      = '0;
        len_wr.q    = qi;
        len_wr.slot = t_cur;
        len_wr.len  = pc1;

        len_rd      = '0;
        len_rd.q    = qi;
        len_rd.slot = h_cur;

        pay_rd      = '0;
        pay_rd.q    = pop_q_reg;
        pay_rd.slot = pop_slot_reg;
        pay_rd.ofs  = k_reg[mqf_pkg::OFS_W-1:0];

        unique case (state_reg)
            mqf_pkg::S_IDLE:
            begin
                // Hold requests while a finished beat cannot leave.
                req_stall = !out_free;
                accept    = req_valid && out_free;
                if (accept && q_ok)
                begin
                    if (is_push)
                    begin
                        // Write the byte straight into the tail slot.
                        pay_wr.en = byte_in && room && !q_full;
                        if (req.last)
                        begin
                            commit          = push_status == mqf_pkg::STAT_OK;
                            len_wr.en       = commit;
                            out_load        = 1'b1;
                            out_data.kind   = mqf_pkg::KIND_PUSH;
                            out_data.status = push_status;
                            out_data.length = commit ? pc1 : '0;
                            out_data.out_last = 1'b1;
                        end
                    end
                    else if (q_empty)
                    begin
                        out_load          = 1'b1;
                        out_data.kind     = mqf_pkg::KIND_POP;
                        out_data.status   = mqf_pkg::STAT_EMPTY;
                        out_data.out_last = 1'b1;
                    end
                    else
                    begin
                        pop_start = 1'b1;
                        len_rd.en = 1'b1;
                    end
                end
            end

            mqf_pkg::S_POP_LEN:
            begin
                // Length read data returns here and is captured; nothing to drive.
                req_stall = 1'b1;
            end

            mqf_pkg::S_POP_DATA:
            begin
                req_stall = 1'b1;
                if (pop_len_reg == '0)
                begin
                    // Message with no bytes: one closing beat.
                    out_load          = out_free;
                    out_data.kind     = mqf_pkg::KIND_POP;
                    out_data.status   = mqf_pkg::STAT_OK;
                    out_data.out_last = 1'b1;
                    pop_done          = out_free;
                end
                else
                begin
                    deliver   = rd_pend_reg && out_free;
                    issue     = (k_reg < pop_len_reg) && (!rd_pend_reg || out_free);
                    pay_rd.en = issue;
                    out_load  = deliver;
                    out_data.kind      = mqf_pkg::KIND_POP;
                    out_data.status    = mqf_pkg::STAT_OK;
                    out_data.length    = pop_len_reg;
                    out_data.out_byte  = pay_rdata;
                    out_data.out_valid = 1'b1;
                    out_data.out_last  = rd_last_reg;
                    pop_done           = deliver && rd_last_reg;
                end
            end

            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mqf_pkg::S_IDLE:
                if (pop_start)
                    state_next = mqf_pkg::S_POP_LEN;
            mqf_pkg::S_POP_LEN:
                state_next = mqf_pkg::S_POP_DATA;
            mqf_pkg::S_POP_DATA:
                if (pop_done)
                    state_next = mqf_pkg::S_IDLE;
            default:
                state_next = mqf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mqf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                slots_reg[i] <= mqf_pkg::SLOTS_RESET;
                bytes_reg[i] <= mqf_pkg::BYTES_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            // Drop writes beyond the register list.
            if (cfg_index < mqf_pkg::CFG_BYTES_BASE)
                slots_reg[mqf_pkg::QID_W'(cfg_index - mqf_pkg::CFG_SLOTS_BASE)]
                    <= cfg_data[mqf_pkg::NSLOT_W-1:0];
            else if (cfg_index < mqf_pkg::CFG_END)
                bytes_reg[mqf_pkg::QID_W'(cfg_index - mqf_pkg::CFG_BYTES_BASE)] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Ring pointers, flags and push accounting.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            full_reg  <= '0;
            empty_reg <= '1;
            pc_reg    <= '0;
            err_reg   <= mqf_pkg::STAT_OK;
        end
        else
        begin
            if (commit)
            begin
                tail_reg[qi]  <= t_adv;
                empty_reg[qi] <= 1'b0;
                full_reg[qi]  <= t_adv == h_cur;
            end
            if (pop_start)
            begin
                head_reg[qi]  <= h_adv;
                full_reg[qi]  <= 1'b0;
                empty_reg[qi] <= t_cur == h_adv;
            end
            if (accept && q_ok && is_push)
            begin
                // Clear message state on the closing beat, else advance it.
                if (req.last)
                begin
                    pc_reg  <= '0;
                    err_reg <= mqf_pkg::STAT_OK;
                end
                else
                begin
                    pc_reg  <= pc1;
                    err_reg <= err1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pop streaming: one payload read ahead of the output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_q_reg    <= '0;
            pop_slot_reg <= '0;
            pop_len_reg  <= '0;
            k_reg        <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            if (pop_start)
            begin
                pop_q_reg    <= qi;
                pop_slot_reg <= h_cur;
            end
            if (state_reg == mqf_pkg::S_POP_LEN)
            begin
                pop_len_reg <= len_rdata;
                k_reg       <= '0;
                rd_pend_reg <= 1'b0;
            end
            else if (state_reg == mqf_pkg::S_POP_DATA)
            begin
                if (issue)
                begin
                    k_reg       <= k_reg + mqf_pkg::LEN_W'(1);
                    rd_pend_reg <= 1'b1;
                    rd_last_reg <= (k_reg + mqf_pkg::LEN_W'(1)) == pop_len_reg;
                end
                else if (deliver)
                begin
                    rd_pend_reg <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a new beat, or drop the old one once taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_load)
            out_v_reg <= 1'b1;
        else if (!resp_stall)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= out_data;
    end

    assign resp_valid = out_v_reg;
    assign resp       = out_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `MQF_ASSERT(a_full_and_empty, clk, rst_n, (full_reg & empty_reg) == '0, "queue both full and empty")
    `MQF_ASSERT_ALWAYS(a_no_overwrite, clk, out_load |-> (!out_v_reg || !resp_stall), "result beat overwritten")
    `MQF_ASSERT(a_pend_in_pop, clk, rst_n, rd_pend_reg |-> (state_reg == mqf_pkg::S_POP_DATA), "payload read outside pop")
    `MQF_ASSERT(a_pop_count, clk, rst_n, (state_reg == mqf_pkg::S_POP_DATA) |-> (k_reg <= pop_len_reg), "pop read past message end")
    `MQF_ASSERT(a_push_count, clk, rst_n, pc_reg <= mqf_pkg::LEN_W'(mqf_pkg::MAX_SLOT_BYTES), "push count beyond slot size")

endmodule
